FILE: design/bdc_pkg.sv
// Shared types and constants of the TLV deframer with CRC-16 check.
`timescale 1ns / 1ps
package bdc_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] LIMIT_FIELD_OFFSET = 16'd0;

    localparam logic [15:0] RST_INIT_LIMIT = 16'd256;
    localparam logic [7:0] RST_CONFIG_CODE = 8'd1;
    localparam logic [7:0] RST_SCHEMA_CODE = 8'd2;
    localparam logic [7:0] RST_DATA_CODE = 8'd3;

    typedef enum logic [1:0] {
        REG_INIT_LIMIT = 2'd0,
        REG_CONFIG_CODE = 2'd1,
        REG_SCHEMA_CODE = 2'd2,
        REG_DATA_CODE = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        STAT_OK = 3'd0,
        STAT_BAD_TYPE = 3'd1,
        STAT_TOO_LONG = 3'd2,
        STAT_CRC_BAD = 3'd3,
        STAT_LIMIT_BIG = 3'd4
    } status_t;

    typedef enum logic {
        KIND_CONTENT = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] config_code;
        logic [7:0] schema_code;
        logic [7:0] data_code;
        logic limit_load;
        logic [15:0] load_value;
    } cfg_t;

    typedef struct packed {
        kind_t kind;
        logic [7:0] content_byte;
        status_t status;
        logic [7:0] frame_type;
        logic [15:0] frame_length;
        logic last;
    } result_t;

endpackage

FILE: design/bdc_apb_regs.sv
// APB configuration registers: limit and type codes.
`timescale 1ns / 1ps
module bdc_apb_regs
    import bdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [15:0] init_limit_reg;
    logic [7:0] config_code_reg;
    logic [7:0] schema_code_reg;
    logic [7:0] data_code_reg;
    logic wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_limit_reg <= RST_INIT_LIMIT;
            config_code_reg <= RST_CONFIG_CODE;
            schema_code_reg <= RST_SCHEMA_CODE;
            data_code_reg <= RST_DATA_CODE;
        end else if (wr_en) begin
            unique case (idx)
                REG_INIT_LIMIT: init_limit_reg <= pwdata[15:0];
                REG_CONFIG_CODE: config_code_reg <= pwdata[7:0];
                REG_SCHEMA_CODE: schema_code_reg <= pwdata[7:0];
                REG_DATA_CODE: data_code_reg <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INIT_LIMIT: prdata = {16'h0000, init_limit_reg};
            REG_CONFIG_CODE: prdata = {24'h000000, config_code_reg};
            REG_SCHEMA_CODE: prdata = {24'h000000, schema_code_reg};
            REG_DATA_CODE: prdata = {24'h000000, data_code_reg};
        endcase
    end

    always_comb begin
        cfg.config_code = config_code_reg;
        cfg.schema_code = schema_code_reg;
        cfg.data_code = data_code_reg;
        cfg.limit_load = wr_en && (idx == REG_INIT_LIMIT);
        cfg.load_value = pwdata[15:0];
    end

endmodule

FILE: design/bdc_crc16_byte.sv
// One-byte CRC-16/MODBUS update (reflected polynomial).
`timescale 1ns / 1ps
module bdc_crc16_byte
    import bdc_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    logic [15:0] c;

    always_comb begin
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

FILE: design/bdc_parser.sv
// Frame parser: header decode, length and CRC checks, limit adoption.
`timescale 1ns / 1ps
module bdc_parser
    import bdc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_accept,
    input  logic [7:0] in_byte,
    output logic    res_push,
    output result_t res
);

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CONTENT,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [7:0] cur_type_reg, cur_type_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [15:0] seen_reg, seen_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0] rx_lo_reg, rx_lo_next;
    logic [15:0] active_reg, active_next;
    logic [15:0] cap_reg, cap_next;

    logic [15:0] crc_in;
    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] seen_inc;
    logic [15:0] rx_crc;
    logic type_ok;
    logic is_cfg;
    logic has_res;

    assign crc_in = (phase_reg == PH_TYPE) ? CRC_INIT : crc_reg;

    bdc_crc16_byte u_crc (
        .crc_in  (crc_in),
        .data_in (in_byte),
        .crc_out (crc_upd)
    );

    assign len_full = {in_byte, decl_len_reg[7:0]};
    assign seen_inc = seen_reg + 16'd1;
    assign rx_crc = {in_byte, rx_lo_reg};
    assign type_ok = (in_byte == cfg.config_code) || (in_byte == cfg.schema_code)
                     || (in_byte == cfg.data_code);
    assign is_cfg = (cur_type_reg == cfg.config_code);

    always_comb begin
        phase_next = phase_reg;
        cur_type_next = cur_type_reg;
        decl_len_next = decl_len_reg;
        seen_next = seen_reg;
        crc_next = crc_reg;
        rx_lo_next = rx_lo_reg;
        active_next = active_reg;
        cap_next = cap_reg;
        has_res = 1'b0;
        res.kind = KIND_STATUS;
        res.content_byte = 8'h00;
        res.status = STAT_OK;
        res.frame_type = cur_type_reg;
        res.frame_length = decl_len_reg;
        res.last = 1'b0;

        if (in_accept) begin
            unique case (phase_reg)
                PH_TYPE: begin
                    cur_type_next = in_byte;
                    decl_len_next = 16'h0000;
                    seen_next = 16'h0000;
                    cap_next = 16'h0000;
                    if (!type_ok) begin
                        has_res = 1'b1;
                        res.status = STAT_BAD_TYPE;
                        res.frame_type = in_byte;
                        res.frame_length = 16'h0000;
                    end else begin
                        crc_next = crc_upd;
                        phase_next = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    decl_len_next = {8'h00, in_byte};
                    crc_next = crc_upd;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    decl_len_next = len_full;
                    crc_next = crc_upd;
                    if (len_full > active_reg) begin
                        phase_next = PH_TYPE;
                        has_res = 1'b1;
                        res.status = STAT_TOO_LONG;
                        res.frame_length = len_full;
                    end else if (len_full == 16'h0000) begin
                        phase_next = PH_CRC_LO;
                    end else begin
                        phase_next = PH_CONTENT;
                    end
                end
                PH_CONTENT: begin
                    crc_next = crc_upd;
                    if (is_cfg) begin
                        if (seen_reg == LIMIT_FIELD_OFFSET) begin
                            cap_next = {cap_reg[15:8], in_byte};
                        end else if (seen_reg == LIMIT_FIELD_OFFSET + 16'd1) begin
                            cap_next = {in_byte, cap_reg[7:0]};
                        end
                    end
                    seen_next = seen_inc;
                    has_res = 1'b1;
                    res.kind = KIND_CONTENT;
                    res.content_byte = in_byte;
                    res.last = (seen_inc == decl_len_reg);
                    if (seen_inc == decl_len_reg) begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    rx_lo_next = in_byte;
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    phase_next = PH_TYPE;
                    has_res = 1'b1;
                    if (rx_crc != crc_reg) begin
                        res.status = STAT_CRC_BAD;
                    end else if (is_cfg && (cap_reg > active_reg)) begin
                        res.status = STAT_LIMIT_BIG;
                    end else if (is_cfg) begin
                        active_next = cap_reg;
                    end
                end
                default: begin
                    phase_next = PH_TYPE;
                end
            endcase
        end

        if (cfg.limit_load) begin
            active_next = cfg.load_value;
        end
    end

    assign res_push = has_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            cur_type_reg <= 8'h00;
            decl_len_reg <= 16'h0000;
            seen_reg <= 16'h0000;
            crc_reg <= CRC_INIT;
            rx_lo_reg <= 8'h00;
            active_reg <= RST_INIT_LIMIT;
            cap_reg <= 16'h0000;
        end else begin
            phase_reg <= phase_next;
            cur_type_reg <= cur_type_next;
            decl_len_reg <= decl_len_next;
            seen_reg <= seen_next;
            crc_reg <= crc_next;
            rx_lo_reg <= rx_lo_next;
            active_reg <= active_next;
            cap_reg <= cap_next;
        end
    end

endmodule

FILE: design/bdc_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
module bdc_out_buf
    import bdc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic pop;

    assign pop = main_valid_reg && out_ready;
    assign space = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next = main_reg;
        skid_next = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_next = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_next = push_data;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_next = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: design/block_deframer_crc16.sv
// Top level of the TLV deframer with CRC-16/MODBUS check.
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+--------------------------------
//  s_        | in  | s_tvalid / s_tready        | s_tdata: raw stream byte
//  m_        | out | m_tvalid / m_tready        | m_tdata, m_tuser (kind), m_tlast
//  apb       | in  | psel / penable, pready = 1 | 4 registers at 0x0, 0x4, 0x8, 0xC
//
// One stream byte is taken per cycle while s_tready is high; each beat is decoded
// in the cycle it is accepted and its result, if any, lands in the output buffer at
// that edge. The two-entry output buffer sets s_tready.
// s_tready drops only while both output entries are full.
// Reset is synchronous on aresetn and clears all control state.
`timescale 1ns / 1ps
module block_deframer_crc16
    import bdc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] in_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] content_byte, [10:8] frame_status, [18:11] frame_type,
    // [34:19] frame_length, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,   // [0] out_kind
    output logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    cfg_t cfg;
    result_t res;
    result_t out_res;
    logic res_push;
    logic in_accept;
    logic space;

    assign s_tready = space;
    assign in_accept = s_tvalid && space;

    bdc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .res_push  (res_push),
        .res       (res)
    );

    bdc_out_buf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {5'b00000, out_res.frame_length, out_res.frame_type,
                      out_res.status, out_res.content_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output register empty");

    a_status_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (!m_tlast && (m_tdata[7:0] == 8'h00)))
        else $error("status beat carries content fields");

    a_content_beat_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[10:8] == STAT_OK))
        else $error("content beat carries a status code");

    a_bad_type_no_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && (m_tdata[10:8] == STAT_BAD_TYPE))
        |-> (m_tdata[34:19] == 16'h0000))
        else $error("bad type status with nonzero length");

endmodule

FILE: tb/tb.sv
// Testbench for the TLV deframer: byte stream in, content and frame status out.
`timescale 1ns / 1ps
module tb;
    import bdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 150;
    localparam int NUM_PHASES = 6;

    typedef enum logic [2:0] {
        AT_TYPE,
        AT_LEN_LO,
        AT_LEN_HI,
        AT_CONTENT,
        AT_CRC_LO,
        AT_CRC_HI
    } parse_t;

    class deframer_board;
        logic [15:0] init_limit;
        logic [15:0] active_limit;
        logic [7:0]  config_code;
        logic [7:0]  schema_code;
        logic [7:0]  data_code;
        parse_t      ph;
        logic [7:0]  cur_type;
        logic [15:0] decl_len;
        logic [15:0] seen;
        logic [15:0] crc;
        logic [7:0]  crc_lo;
        logic [15:0] captured;
        result_t     pending_results[$];
        int          errors;
        int          n_results;
        int          status_seen[5];

        function new();
            init_limit = RST_INIT_LIMIT;
            active_limit = RST_INIT_LIMIT;
            config_code = RST_CONFIG_CODE;
            schema_code = RST_SCHEMA_CODE;
            data_code = RST_DATA_CODE;
            ph = AT_TYPE;
            cur_type = '0;
            decl_len = '0;
            seen = '0;
            crc = CRC_INIT;
            crc_lo = '0;
            captured = '0;
            errors = 0;
            n_results = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            c = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_INIT_LIMIT: begin
                    init_limit = v[15:0];
                    active_limit = v[15:0];
                end
                REG_CONFIG_CODE: config_code = v[7:0];
                REG_SCHEMA_CODE: schema_code = v[7:0];
                REG_DATA_CODE:   data_code = v[7:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            result_t r;
            bit      emit;
            r = '0;
            emit = 0;
            r.frame_type = cur_type;
            case (ph)
                AT_TYPE: begin
                    cur_type = b;
                    decl_len = '0;
                    seen = '0;
                    captured = '0;
                    if (b != config_code && b != schema_code && b != data_code) begin
                        r.kind = KIND_STATUS;
                        r.status = STAT_BAD_TYPE;
                        r.frame_type = b;
                        emit = 1;
                    end else begin
                        crc = crc_step(CRC_INIT, b);
                        ph = AT_LEN_LO;
                    end
                end
                AT_LEN_LO: begin
                    decl_len = {8'h00, b};
                    crc = crc_step(crc, b);
                    ph = AT_LEN_HI;
                end
                AT_LEN_HI: begin
                    decl_len[15:8] = b;
                    crc = crc_step(crc, b);
                    if (decl_len > active_limit) begin
                        ph = AT_TYPE;
                        r.kind = KIND_STATUS;
                        r.status = STAT_TOO_LONG;
                        r.frame_length = decl_len;
                        emit = 1;
                    end else begin
                        ph = (decl_len == 0) ? AT_CRC_LO : AT_CONTENT;
                    end
                end
                AT_CONTENT: begin
                    crc = crc_step(crc, b);
                    if (cur_type == config_code) begin
                        if (seen == LIMIT_FIELD_OFFSET)
                            captured[7:0] = b;
                        else if (seen == LIMIT_FIELD_OFFSET + 16'd1)
                            captured[15:8] = b;
                    end
                    seen = seen + 16'd1;
                    r.kind = KIND_CONTENT;
                    r.content_byte = b;
                    r.frame_length = decl_len;
                    r.last = (seen == decl_len);
                    if (r.last)
                        ph = AT_CRC_LO;
                    emit = 1;
                end
                AT_CRC_LO: begin
                    crc_lo = b;
                    ph = AT_CRC_HI;
                end
                AT_CRC_HI: begin
                    ph = AT_TYPE;
                    r.kind = KIND_STATUS;
                    r.frame_length = decl_len;
                    if ({b, crc_lo} != crc) begin
                        r.status = STAT_CRC_BAD;
                    end else if (cur_type == config_code && captured > active_limit) begin
                        r.status = STAT_LIMIT_BIG;
                    end else begin
                        if (cur_type == config_code)
                            active_limit = captured;
                        r.status = STAT_OK;
                    end
                    emit = 1;
                end
                default: ph = AT_TYPE;
            endcase
            if (emit) begin
                pending_results.push_back(r);
                if (r.kind == KIND_STATUS)
                    status_seen[r.status]++;
            end
        endfunction

        function void cmp(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: tdata fields %h", got);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            cmp("out_kind", e.kind, got.kind);
            cmp("content_byte", e.content_byte, got.content_byte);
            cmp("frame_status", e.status, got.status);
            cmp("frame_type", e.frame_type, got.frame_type);
            cmp("frame_length", e.frame_length, got.frame_length);
            cmp("content_last", e.last, got.last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    deframer_board sb = new();
    result_t got_beat;
    bit          gaps_on = 1'b1;
    int          stall_left = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          n_writes = 0;
    int          n_settings = 0;

    block_deframer_crc16 uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1) begin
                sb.write_reg(reg_idx_t'(paddr[3:2]), pwdata);
                n_writes++;
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                sb.note_byte(s_tdata);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                got_beat.kind = kind_t'(m_tuser);
                got_beat.content_byte = m_tdata[7:0];
                got_beat.status = status_t'(m_tdata[10:8]);
                got_beat.frame_type = m_tdata[18:11];
                got_beat.frame_length = m_tdata[34:19];
                got_beat.last = m_tlast;
                sb.check_result(got_beat);
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        bytes_sent++;
    endtask

    // keep < 0 sends the whole frame, otherwise only its first keep bytes
    task automatic send_frame(logic [7:0] ftype, int len, logic [15:0] lim, bit bad_crc,
                              int keep);
        logic [7:0]  fb[$];
        logic [15:0] c;
        logic [15:0] flen;
        int          n;
        flen = len[15:0];
        fb.push_back(ftype);
        fb.push_back(flen[7:0]);
        fb.push_back(flen[15:8]);
        for (int i = 0; i < len && (keep < 0 || fb.size() < keep); i++) begin
            if (i == LIMIT_FIELD_OFFSET)
                fb.push_back(lim[7:0]);
            else if (i == LIMIT_FIELD_OFFSET + 1)
                fb.push_back(lim[15:8]);
            else
                fb.push_back(8'($urandom_range(0, 255)));
        end
        c = CRC_INIT;
        foreach (fb[k]) c = sb.crc_step(c, fb[k]);
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
        n = (keep < 0 || keep > fb.size()) ? fb.size() : keep;
        for (int k = 0; k < n; k++) send_byte(fb[k]);
    endtask

    task automatic rand_frame();
        int          pick;
        int          len;
        int          keep;
        logic [7:0]  t;
        logic [15:0] lim;
        logic [15:0] act;
        act = sb.active_limit;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
            t = sb.config_code;
        else if (pick < 6)
            t = sb.schema_code;
        else if (pick < 9)
            t = sb.data_code;
        else
            t = 8'($urandom_range(0, 255));
        len = $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(0, 65535);
            if (len > 12 && len <= act)
                len = len % 13;
        end else if ($urandom_range(0, 9) == 0 && act < 16'hFFFF) begin
            len = act + 1;
        end
        keep = (len > act) ? 3 : -1;
        if ($urandom_range(0, 19) == 0)
            keep = $urandom_range(1, (len > 12 ? 12 : len) + 4);
        case ($urandom_range(0, 3))
            0: lim = 16'($urandom_range(0, 12));
            1: lim = act;
            2: lim = 16'(act + $urandom_range(1, 40));
            default: lim = 16'($urandom_range(0, 65535));
        endcase
        send_frame(t, len, lim, $urandom_range(0, 9) == 0, keep);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        logic [15:0] lim_tab[NUM_PHASES];
        logic [7:0]  cfg_tab[NUM_PHASES];
        logic [7:0]  sch_tab[NUM_PHASES];
        logic [7:0]  dat_tab[NUM_PHASES];
        int          start;
        lim_tab = '{16'd16, 16'd0, 16'hFFFF, 16'd8, 16'd20, 16'd24};
        cfg_tab = '{8'd1, 8'd0, 8'hFF, 8'h5A, 8'd0, 8'd1};
        sch_tab = '{8'd2, 8'hFF, 8'hFF, 8'hA5, 8'd0, 8'd2};
        dat_tab = '{8'd3, 8'h80, 8'd7, 8'h00, 8'd0, 8'd3};
        lim_tab[4] = 16'($urandom_range(4, 40));
        cfg_tab[4] = 8'($urandom_range(0, 255));
        sch_tab[4] = 8'($urandom_range(0, 255));
        dat_tab[4] = 8'($urandom_range(0, 255));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(RST_DATA_CODE, 0, 16'h0000, 1'b0, -1);
        send_frame(RST_SCHEMA_CODE, 1, 16'h00FF, 1'b0, -1);
        send_frame(RST_DATA_CODE, 16'hFFFF, 16'h0000, 1'b0, 3);
        send_frame(RST_CONFIG_CODE, 2, 16'h0200, 1'b0, -1);
        send_frame(RST_CONFIG_CODE, 2, 16'h0009, 1'b0, -1);
        send_frame(RST_DATA_CODE, 1, 16'h0000, 1'b1, -1);
        send_frame(RST_CONFIG_CODE, 1, 16'h0005, 1'b0, -1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            gaps_on = (p != NUM_PHASES - 1);
            apb_write(REG_INIT_LIMIT, {16'h0000, lim_tab[p]});
            apb_write(REG_CONFIG_CODE, {24'h0, cfg_tab[p]});
            apb_write(REG_SCHEMA_CODE, {24'h0, sch_tab[p]});
            apb_write(REG_DATA_CODE, {24'h0, dat_tab[p]});
            n_settings++;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) rand_frame();
        end
        settle();

        $display("Run covered %0d stream bytes, %0d result beats, %0d register writes, %0d settings",
                 bytes_sent, sb.n_results, n_writes, n_settings);
        $display("Frame ends: ok %0d, bad type %0d, too long %0d, crc bad %0d, limit big %0d",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_BAD_TYPE],
                 sb.status_seen[STAT_TOO_LONG], sb.status_seen[STAT_CRC_BAD],
                 sb.status_seen[STAT_LIMIT_BIG]);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.pending_results.size() != 0)
                $error("%0d expected results never arrived", sb.pending_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bdc_pkg.sv
design/bdc_apb_regs.sv
design/bdc_crc16_byte.sv
design/bdc_parser.sv
design/bdc_out_buf.sv
design/block_deframer_crc16.sv
tb/tb.sv
